// ----- src/tjb_pkg.sv -----
package tjb_pkg;

    localparam int MAX_SITES   = 8;
    localparam int TABLE_DEPTH = 8192;
    localparam int WORD_W      = 2 * MAX_SITES;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SITE_W      = 4;
    localparam int POP_W       = $clog2(MAX_SITES + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SITE_COUNT     = 3'd0,
        REG_USE_UP_COUNT   = 3'd1,
        REG_UP_COUNT       = 3'd2,
        REG_USE_DOWN_COUNT = 3'd3,
        REG_DOWN_COUNT     = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        FUNC_BUILD = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_SEARCH,
        S_CMP,
        S_CHECK,
        S_POS,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_ctrl_t;

endpackage

// ----- src/tjb_in_if.sv -----
interface tjb_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [tjb_pkg::WORD_W-1:0] query_state;
    logic [tjb_pkg::ADDR_W-1:0] query_position;

    modport source (output valid, func, query_state, query_position, input ready);
    modport sink (input valid, func, query_state, query_position, output ready);
endinterface

// ----- src/tjb_out_if.sv -----
interface tjb_out_if;
    logic                       valid;
    logic                       ready;
    logic [tjb_pkg::CNT_W-1:0]  table_size;
    logic                       state_found;
    logic [tjb_pkg::ADDR_W-1:0] found_index;
    logic                       position_valid;
    logic [tjb_pkg::WORD_W-1:0] state_at_position;
    logic                       overflow;

    modport source (output valid, table_size, state_found, found_index, position_valid,
        state_at_position, overflow, input ready);
    modport sink (input valid, table_size, state_found, found_index, position_valid,
        state_at_position, overflow, output ready);
endinterface

// ----- src/tjb_cfg_if.sv -----
interface tjb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tjb_pkg::CFG_IDX_W-1:0]  index;
    logic [tjb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/tjb_table_ram.sv -----
module tjb_table_ram (
    input  logic                       clk,
    input  tjb_pkg::ram_ctrl_t         ctrl,
    output logic [tjb_pkg::WORD_W-1:0] rd_data
);
    import tjb_pkg::*;

    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[ctrl.waddr] <= ctrl.wdata;
        end
        rd_data <= mem[ctrl.raddr];
    end
endmodule

// ----- src/tj_basis_table_build_and_lookup.sv -----
// Build: one candidate word per cycle through a shared occupancy and popcount check;
//   an invalid site count goes straight to the result without building.
// Query: binary search steps over one RAM read port, each a read and a compare,
//   then the accept, the final check, the position read and the result load.
// One item at a time; the output register lets the next item start while a result waits.
// Reset clears size, overflow, settings, but site count is 1; table contents undefined.
module tj_basis_table_build_and_lookup (
    input  logic clk,
    input  logic rst_n,
    tjb_cfg_if.sink   cfg,
    tjb_in_if.sink    req,
    tjb_out_if.source rsp
);
    import tjb_pkg::*;

    state_t state_reg, state_next;

    logic [SITE_W-1:0] site_reg, site_next;
    logic              use_up_reg, use_up_next;
    logic [SITE_W-1:0] up_reg, up_next;
    logic              use_dn_reg, use_dn_next;
    logic [SITE_W-1:0] dn_reg, dn_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              overflow_reg, overflow_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [WORD_W-1:0] qs_reg, qs_next;
    logic [ADDR_W-1:0] qp_reg, qp_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] fidx_reg, fidx_next;
    logic              pvalid_reg, pvalid_next;
    logic [WORD_W-1:0] pword_reg, pword_next;

    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  o_size_reg, o_size_next;
    logic              o_found_reg, o_found_next;
    logic [ADDR_W-1:0] o_fidx_reg, o_fidx_next;
    logic              o_pvalid_reg, o_pvalid_next;
    logic [WORD_W-1:0] o_pword_reg, o_pword_next;
    logic              o_ovf_reg, o_ovf_next;

    ram_ctrl_t         ram_ctrl;
    logic [WORD_W-1:0] rd_data;

    logic              in_beat;
    logic              sites_ok;
    logic [WORD_W-1:0] last_word;
    logic [WORD_W-1:0] up_bits;
    logic [WORD_W-1:0] dn_bits;
    logic              keep;
    logic [CNT_W-1:0]  mid;
    logic              out_free;

    function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] v);
        logic [POP_W-1:0] c;
        c = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            c = c + POP_W'(v[i]);
        end
        return c;
    endfunction

    tjb_table_ram u_ram (
        .clk     (clk),
        .ctrl    (ram_ctrl),
        .rd_data (rd_data)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign in_beat   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign sites_ok  = (site_reg != '0) && (site_reg <= SITE_W'(MAX_SITES));
    assign last_word = ~({WORD_W{1'b1}} << {site_reg, 1'b0});
    for (genvar g = 0; g < WORD_W; g++)
    begin : g_mask
        assign up_bits[g] = (g % 2 == 0) ? word_reg[g] : 1'b0;
        assign dn_bits[g] = (g % 2 == 1) ? word_reg[g] : 1'b0;
    end
    assign keep = ((up_bits & (dn_bits >> 1)) == '0)
        && (!use_up_reg || (SITE_W'(popcount(up_bits)) == up_reg))
        && (!use_dn_reg || (SITE_W'(popcount(dn_bits)) == dn_reg));
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    if (func_t'(req.func) == FUNC_QUERY)
                    begin
                        state_next = S_SEARCH;
                    end
                    else if (sites_ok)
                    begin
                        state_next = S_BUILD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_BUILD:
            begin
                if ((keep && count_reg == CNT_W'(TABLE_DEPTH)) || word_reg == last_word)
                begin
                    state_next = S_DONE;
                end
            end
            S_SEARCH:
            begin
                state_next = (lo_reg < hi_reg) ? S_CMP : S_CHECK;
            end
            S_CMP:   state_next = S_SEARCH;
            S_CHECK: state_next = S_POS;
            S_POS:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        site_next      = site_reg;
        use_up_next    = use_up_reg;
        up_next        = up_reg;
        use_dn_next    = use_dn_reg;
        dn_next        = dn_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        word_next      = word_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        qs_next        = qs_reg;
        qp_next        = qp_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        pvalid_next    = pvalid_reg;
        pword_next     = pword_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        o_size_next    = o_size_reg;
        o_found_next   = o_found_reg;
        o_fidx_next    = o_fidx_reg;
        o_pvalid_next  = o_pvalid_reg;
        o_pword_next   = o_pword_reg;
        o_ovf_next     = o_ovf_reg;
        ram_ctrl.we    = 1'b0;
        ram_ctrl.waddr = count_reg[ADDR_W-1:0];
        ram_ctrl.wdata = word_reg;
        ram_ctrl.raddr = mid[ADDR_W-1:0];

        if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_SITE_COUNT:     site_next   = cfg.data;
                REG_USE_UP_COUNT:   use_up_next = cfg.data[0];
                REG_UP_COUNT:       up_next     = cfg.data;
                REG_USE_DOWN_COUNT: use_dn_next = cfg.data[0];
                REG_DOWN_COUNT:     dn_next     = cfg.data;
                default:            ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    qs_next     = req.query_state;
                    qp_next     = req.query_position;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    word_next   = '0;
                    found_next  = 1'b0;
                    fidx_next   = '0;
                    pvalid_next = 1'b0;
                    pword_next  = '0;
                    if (func_t'(req.func) == FUNC_BUILD)
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                    end
                end
            end
            S_BUILD:
            begin
                word_next = word_reg + 1'b1;
                if (keep)
                begin
                    if (count_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        ram_ctrl.we = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
            end
            S_SEARCH:
            begin
                if (lo_reg >= hi_reg)
                begin
                    ram_ctrl.raddr = lo_reg[ADDR_W-1:0];
                end
            end
            S_CMP:
            begin
                if (rd_data < qs_reg)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
            end
            S_CHECK:
            begin
                ram_ctrl.raddr = qp_reg;
                if (lo_reg < count_reg && rd_data == qs_reg)
                begin
                    found_next = 1'b1;
                    fidx_next  = lo_reg[ADDR_W-1:0];
                end
            end
            S_POS:
            begin
                if (CNT_W'(qp_reg) < count_reg)
                begin
                    pvalid_next = 1'b1;
                    pword_next  = rd_data;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_size_next    = count_reg;
                    o_found_next   = found_reg;
                    o_fidx_next    = fidx_reg;
                    o_pvalid_next  = pvalid_reg;
                    o_pword_next   = pword_reg;
                    o_ovf_next     = overflow_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            site_reg      <= SITE_W'(1);
            use_up_reg    <= 1'b0;
            up_reg        <= '0;
            use_dn_reg    <= 1'b0;
            dn_reg        <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            site_reg      <= site_next;
            use_up_reg    <= use_up_next;
            up_reg        <= up_next;
            use_dn_reg    <= use_dn_next;
            dn_reg        <= dn_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        qs_reg       <= qs_next;
        qp_reg       <= qp_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        pvalid_reg   <= pvalid_next;
        pword_reg    <= pword_next;
        o_size_reg   <= o_size_next;
        o_found_reg  <= o_found_next;
        o_fidx_reg   <= o_fidx_next;
        o_pvalid_reg <= o_pvalid_next;
        o_pword_reg  <= o_pword_next;
        o_ovf_reg    <= o_ovf_next;
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.table_size        = o_size_reg;
    assign rsp.state_found       = o_found_reg;
    assign rsp.found_index       = o_fidx_reg;
    assign rsp.position_valid    = o_pvalid_reg;
    assign rsp.state_at_position = o_pword_reg;
    assign rsp.overflow          = o_ovf_reg;

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctrl.we |-> count_reg < CNT_W'(TABLE_DEPTH))
        else $error("table write past depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> count_reg == CNT_W'(TABLE_DEPTH))
        else $error("overflow without full table");

    a_cmp_interval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> lo_reg < hi_reg && hi_reg <= count_reg)
        else $error("search interval broken");

    a_done_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_free |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not loaded");
endmodule
